/* rtl/pwo_pkg.sv */
// Package for the packet word obfuscator: key tables, key byte bases,
// register map constants and the per-word key function.
// No dependencies.
package pwo_pkg;

  // Register map
  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] RegKeyTable = 3'd0;

  // Direction codes carried in tuser
  localparam logic OpObfuscate = 1'b0;
  localparam logic OpRestore   = 1'b1;

  // Key table selector codes (the unused code falls back to the first table)
  localparam logic [1:0] SelFirst  = 2'd0;
  localparam logic [1:0] SelSecond = 2'd1;
  localparam logic [1:0] SelThird  = 2'd2;

  typedef logic [7:0] byte_t;

  // Fixed part of key byte j: 0xa5 | (j << j) | j
  localparam byte_t KeyBase [4] = '{8'hA5, 8'hA7, 8'hAF, 8'hBF};

  localparam byte_t TableFirst [16] = '{
    8'h7A, 8'h64, 8'h05, 8'hF1, 8'h1B, 8'h9B, 8'hA0, 8'hB5,
    8'hCA, 8'hED, 8'h61, 8'h0D, 8'h4A, 8'hDF, 8'h8E, 8'hC7};
  localparam byte_t TableSecond [16] = '{
    8'h05, 8'h61, 8'h7A, 8'hED, 8'h1B, 8'hCA, 8'h0D, 8'h9B,
    8'h4A, 8'hF1, 8'h64, 8'hC7, 8'hB5, 8'h8E, 8'hDF, 8'hA0};
  localparam byte_t TableThird [16] = '{
    8'h20, 8'h07, 8'h13, 8'h61, 8'h03, 8'h45, 8'h17, 8'h72,
    8'h0A, 8'h2D, 8'h48, 8'h0C, 8'h4A, 8'h12, 8'hA9, 8'hB5};

  // One byte of the selected table
  function automatic byte_t table_byte(input logic [1:0] sel, input logic [3:0] idx);
    byte_t b;
    case (sel)
      SelSecond: b = TableSecond[idx];
      SelThird:  b = TableThird[idx];
      default:   b = TableFirst[idx];
    endcase
    return b;
  endfunction

  // Four key bytes for one word position, key byte j in bits 8j+7..8j
  function automatic logic [31:0] word_key(input logic [1:0] sel, input logic [3:0] pos);
    logic [31:0] k;
    logic [3:0]  idx;
    k = '0;
    for (int j = 0; j < 4; j++) begin
      idx = pos + 4'(j);
      k[8*j +: 8] = KeyBase[j] | table_byte(sel, idx);
    end
    return k;
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* rtl/pwo_xform.sv */
// Word transform of the packet word obfuscator: whitening, byte swap and
// key mixing in either direction. Pure combinational logic.
// Depends on pwo_pkg.
module pwo_xform (
  input  logic        op_i,
  input  logic [31:0] word_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] key_i,
  output logic [31:0] result_o
);
  import pwo_pkg::*;

  logic [31:0] fwd;
  logic [31:0] rev;

  // Forward: swap(word ^ ~seq) ^ key ^ seq
  assign fwd = swap_bytes(word_i ^ ~seq_i) ^ key_i ^ seq_i;
  // Reverse: swap(word ^ seq ^ key) ^ ~seq
  assign rev = swap_bytes(word_i ^ seq_i ^ key_i) ^ ~seq_i;

  assign result_o = (op_i == OpRestore) ? rev : fwd;

endmodule

/* rtl/packet_word_obfuscator.sv */
// Top level of the packet word obfuscator: stream ports, APB register,
// word position counter and output stage with skid buffer.
// Depends on pwo_pkg and pwo_xform.
//
//   channel   direction  fields
//   s_axis    in         tdata {sequence_req, payload_word}, tuser operation,
//                        tlast last_word
//   m_axis    out        tdata result_word, tlast result_last
//   apb       in/out     key_table at byte address 0
//
// One item per cycle while m_axis accepts; a result goes into the output register, or into
// the skid register while m_axis stalls. The transform sits between the input handshake and
// the output register; a one-deep skid register keeps s_axis_tready registered.
// Reset clears the word position, the key table selector and both valids.
// While m_axis stalls, one further item is taken into the skid register.
module packet_word_obfuscator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // stream in
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // [31:0] payload_word, [63:32] sequence_req
  input  logic                       s_axis_tuser,  // [0] operation
  input  logic                       s_axis_tlast,
  // stream out
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // [31:0] result_word
  output logic                       m_axis_tlast,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pwo_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pwo_pkg::*;

  logic [1:0]  key_table_q;
  logic [3:0]  pos_q;
  logic        in_fire;
  logic [31:0] key;
  logic [31:0] result;

  logic        out_v_q;
  logic [31:0] out_word_q;
  logic        out_last_q;
  logic        skid_v_q;
  logic [31:0] skid_word_q;
  logic        skid_last_q;
  logic        out_free;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1:2] == RegKeyTable[PaddrW-1:2]) ? {30'd0, key_table_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_table_q <= SelFirst;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PaddrW-1:2] == RegKeyTable[PaddrW-1:2]) begin
      key_table_q <= pwdata[1:0];
    end
  end

  // Word transform
  assign s_axis_tready = ~skid_v_q;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign key           = word_key(key_table_q, pos_q);

  pwo_xform u_xform (
    .op_i     (s_axis_tuser),
    .word_i   (s_axis_tdata[31:0]),
    .seq_i    (s_axis_tdata[63:32]),
    .key_i    (key),
    .result_o (result)
  );

  // Word position: wraps mod 16, back to zero after a last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= s_axis_tlast ? 4'd0 : pos_q + 4'd1;
    end
  end

  // Output stage and skid control
  assign out_free = ~out_v_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_word_q <= skid_word_q;
        out_last_q <= skid_last_q;
      end else if (in_fire) begin
        out_word_q <= result;
        out_last_q <= s_axis_tlast;
      end
    end else if (in_fire) begin
      skid_word_q <= result;
      skid_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tlast  = out_last_q;

endmodule
